// ===== rtl/qts_pkg.sv =====
// Shared types, codes and helper functions for the query token scanner.
`default_nettype none

package qts_pkg;

  localparam int DEFAULT_POSITION_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_WORD   = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_EQUAL  = 3'd3;
  localparam logic [2:0] KIND_COMMA  = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;
  localparam logic [2:0] KIND_END    = 3'd6;
  localparam logic [2:0] KIND_UNTERM = 3'd7;

  localparam logic [7:0] CH_UNDERSCORE = 8'd95;
  localparam logic [7:0] CH_QUOTE      = 8'd39;
  localparam logic [7:0] CH_EQUAL      = 8'd61;
  localparam logic [7:0] CH_COMMA      = 8'd44;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] position;
    logic [15:0] length;
  } tok_t;

  typedef struct packed {
    tok_t first;
    tok_t second;
    logic dual;
  } tok_pair_t;

  typedef struct packed {
    logic      valid;
    tok_pair_t pair;
  } tok_req_t;

  typedef struct packed {
    logic full;
  } queue_status_t;

  function automatic logic [15:0] sat16(input logic [32:0] v);
    return (v > 33'h0_0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] low16(input logic [31:0] v);
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qts_front.sv =====
// Front end: accepts characters, tracks the scan mode and builds token requests.
`default_nettype none

module qts_front import qts_pkg::*; #(
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire logic          command,
  input  wire logic [7:0]    char_code,
  input  wire queue_status_t status,
  output tok_req_t           req
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING
  } mode_t;

  mode_t                    scan_mode, scan_mode_next;
  logic [POSITION_BITS-1:0] char_position, char_position_next;
  logic [POSITION_BITS-1:0] token_begin, token_begin_next;

  logic                     accept;
  logic                     is_alpha, is_digit, is_under, is_quote, is_equal, is_comma;
  logic                     is_space;
  logic [POSITION_BITS-1:0] d_tb;
  logic [POSITION_BITS:0]   tb_plus, p_wide, d_str;
  logic [15:0]              len_tb, len_str, p16, tb16;
  logic [POSITION_BITS-1:0] advanced;
  logic                     close_valid, start_valid, begin_new;
  tok_t                     close_tok, start_tok;

  assign item_stall = status.full;
  assign accept     = item_valid && !item_stall;

  assign is_alpha = ((char_code >= 8'd65) && (char_code <= 8'd90)) ||
                    ((char_code >= 8'd97) && (char_code <= 8'd122));
  assign is_digit = (char_code >= 8'd48) && (char_code <= 8'd57);
  assign is_under = (char_code == CH_UNDERSCORE);
  assign is_quote = (char_code == CH_QUOTE);
  assign is_equal = (char_code == CH_EQUAL);
  assign is_comma = (char_code == CH_COMMA);
  assign is_space = (char_code == 8'd32) || ((char_code >= 8'd9) && (char_code <= 8'd13));

  assign d_tb    = (char_position > token_begin) ? (char_position - token_begin) : '0;
  assign tb_plus = {1'b0, token_begin} + 1'b1;
  assign p_wide  = {1'b0, char_position};
  assign d_str   = (p_wide > tb_plus) ? (p_wide - tb_plus) : '0;
  assign len_tb  = sat16(33'(d_tb));
  assign len_str = sat16(33'(d_str));
  assign p16     = low16(32'(char_position));
  assign tb16    = low16(32'(token_begin));

  assign advanced = (char_position != {POSITION_BITS{1'b1}}) ?
                    (char_position + 1'b1) : char_position;

  always_comb begin
    close_valid        = 1'b0;
    close_tok          = '{kind: KIND_WORD, position: tb16, length: len_tb};
    start_valid        = 1'b0;
    start_tok          = '{kind: KIND_ERROR, position: p16, length: 16'd1};
    begin_new          = 1'b0;
    scan_mode_next     = scan_mode;
    token_begin_next   = token_begin;
    char_position_next = advanced;
    if (command) begin
      case (scan_mode)
        MODE_WORD: begin
          close_valid = 1'b1;
        end
        MODE_NUMBER: begin
          close_valid    = 1'b1;
          close_tok.kind = KIND_NUMBER;
        end
        MODE_STRING: begin
          close_valid      = 1'b1;
          close_tok.kind   = KIND_UNTERM;
          close_tok.length = len_str;
        end
        default: begin
        end
      endcase
      start_valid        = 1'b1;
      start_tok          = '{kind: KIND_END, position: p16, length: 16'd0};
      scan_mode_next     = MODE_IDLE;
      token_begin_next   = '0;
      char_position_next = '0;
    end else begin
      case (scan_mode)
        MODE_WORD: begin
          if (!(is_alpha || is_digit || is_under)) begin
            close_valid    = 1'b1;
            scan_mode_next = MODE_IDLE;
            begin_new      = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (!is_digit) begin
            close_valid    = 1'b1;
            close_tok.kind = KIND_NUMBER;
            scan_mode_next = MODE_IDLE;
            begin_new      = 1'b1;
          end
        end
        MODE_STRING: begin
          if (is_quote) begin
            close_valid      = 1'b1;
            close_tok.kind   = KIND_STRING;
            close_tok.length = len_str;
            scan_mode_next   = MODE_IDLE;
          end
        end
        default: begin
          begin_new = 1'b1;
        end
      endcase
      if (begin_new) begin
        if (is_alpha || is_under) begin
          scan_mode_next   = MODE_WORD;
          token_begin_next = char_position;
        end else if (is_digit) begin
          scan_mode_next   = MODE_NUMBER;
          token_begin_next = char_position;
        end else if (is_quote) begin
          scan_mode_next   = MODE_STRING;
          token_begin_next = char_position;
        end else if (is_equal) begin
          start_valid = 1'b1;
          start_tok   = '{kind: KIND_EQUAL, position: p16, length: 16'd0};
        end else if (is_comma) begin
          start_valid = 1'b1;
          start_tok   = '{kind: KIND_COMMA, position: p16, length: 16'd0};
        end else if (!is_space) begin
          start_valid = 1'b1;
        end
      end
    end
  end

  always_comb begin
    req.valid       = accept && (close_valid || start_valid);
    req.pair.dual   = close_valid && start_valid;
    req.pair.first  = close_valid ? close_tok : start_tok;
    req.pair.second = start_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      char_position <= '0;
      token_begin   <= '0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      char_position <= char_position_next;
      token_begin   <= token_begin_next;
    end
  end

  a_begin_not_ahead: assert property (@(posedge clk) disable iff (rst)
    token_begin <= char_position)
    else $error("Open token starts beyond the current position.");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && command) |=> (char_position == '0) && (scan_mode == MODE_IDLE))
    else $error("End of query did not return the scanner to its start.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !req.valid)
    else $error("Token request issued while the queue is full.");

endmodule

`default_nettype wire

// ===== rtl/qts_back.sv =====
// Back end: token queue and output register that sends one token per cycle unless token_stall holds it.
`default_nettype none

module qts_back import qts_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tok_req_t      req,
  output queue_status_t      status,
  output logic               token_valid,
  input  wire logic          token_stall,
  output logic [2:0]         token_kind,
  output logic [15:0]        token_position,
  output logic [15:0]        value_length,
  output logic               last_of_run
);

  tok_pair_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count, count_next;
  tok_pair_t                 hold;
  logic                      phase;
  logic                      push, take, finish, load;
  tok_t                      cur;

  assign status.full = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign push        = req.valid && !status.full;
  assign take        = token_valid && !token_stall;
  assign finish      = take && (phase || !hold.dual);
  assign load        = (count != '0) && (!token_valid || finish);

  always_comb begin
    count_next = count;
    if (push && !load) begin
      count_next = count + 1'b1;
    end else if (load && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= req.pair;
    end
    if (load) begin
      hold <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      token_valid <= 1'b0;
      phase       <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr      <= rd_ptr + 1'b1;
        token_valid <= 1'b1;
        phase       <= 1'b0;
      end else if (finish) begin
        token_valid <= 1'b0;
        phase       <= 1'b0;
      end else if (take) begin
        phase <= 1'b1;
      end
    end
  end

  assign cur            = phase ? hold.second : hold.first;
  assign token_kind     = cur.kind;
  assign token_position = cur.position;
  assign value_length   = cur.length;
  assign last_of_run    = phase || !hold.dual;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_phase_dual: assert property (@(posedge clk) disable iff (rst)
    phase |-> (token_valid && hold.dual))
    else $error("Second token shown for a single-token request.");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    (finish && (count == '0)) |=> !token_valid)
    else $error("Output stayed valid after the queue drained.");

endmodule

`default_nettype wire

// ===== rtl/query_token_scanner.sv =====
// Top level of the query token scanner: front end, token queue and output stage.
// The scanner takes one query character, or an end-of-query mark, in every clock cycle unless
// item_stall holds it, and produces tokens with their kind, start position and value length.
// A character that closes a token and is itself a one-character token yields two tokens, and
// so does the end mark when a token is open; those two leave one after the other, so the
// output side sets the sustained rate at one token per cycle while token_stall is low. A
// four-entry queue sits between the character side and the token side, and item_stall rises
// only when it is full. A token passes through a queue entry and the output register first.
`default_nettype none

module query_token_scanner import qts_pkg::*; #(
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        command,
  input  wire logic [7:0]  char_code,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [2:0]       token_kind,
  output logic [15:0]      token_position,
  output logic [15:0]      value_length,
  output logic             last_of_run
);

  tok_req_t      req;
  queue_status_t status;

  qts_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .char_code  (char_code),
    .status     (status),
    .req        (req)
  );

  qts_back u_back (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .status         (status),
    .token_valid    (token_valid),
    .token_stall    (token_stall),
    .token_kind     (token_kind),
    .token_position (token_position),
    .value_length   (value_length),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire
